@@ hw/rtl/frg_pkg.sv @@
// frg_pkg: types and constants for the fraction reducer.
// Used by frg_ctrl, frg_dp and fraction_reduce_gcd; depends on nothing.
`default_nettype none

package frg_pkg;

  localparam int W  = 32;
  localparam int KW = $clog2(W);

  typedef struct packed {
    logic signed [W-1:0] num_in;
    logic signed [W-1:0] den_in;
  } in_t;

  typedef struct packed {
    logic signed [W-1:0] num_out;
    logic [W-2:0]        den_out;
  } out_t;

  typedef struct packed {
    logic load;
    logic halve;
    logic step;
    logic div_init;
    logic div_step;
  } cmd_t;

  typedef struct packed {
    logic zero;
    logic both_even;
    logic a_zero;
  } stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/frg_dp.sv @@
// frg_dp: datapath of the fraction reducer: magnitudes, binary gcd, two
// restoring dividers sharing the gcd divisor, result formatting. Uses frg_pkg.
`default_nettype none

module frg_dp (
  input  wire logic         clk,
  input  wire frg_pkg::in_t  in_data,
  input  wire frg_pkg::cmd_t cmd,
  output frg_pkg::stat_t     stat,
  output frg_pkg::out_t      res
);

  localparam int W  = frg_pkg::W;
  localparam int KW = frg_pkg::KW;

  logic          neg;
  logic          zero;
  logic [W-1:0]  a;
  logic [W-1:0]  b;
  logic [KW-1:0] k;
  logic [W-1:0]  g;
  logic [W-1:0]  qn;
  logic [W-1:0]  qd;
  logic [W-1:0]  remn;
  logic [W-1:0]  remd;

  logic [W-1:0]  nmag;
  logic [W-1:0]  dmag;
  logic [W-1:0]  tn;
  logic [W-1:0]  td;
  logic          gen;
  logic          ged;
  logic [W-1:0]  sub_ab;
  logic [W-1:0]  sub_ba;
  logic [W-1:0]  rneg;

  assign nmag = in_data.num_in[W-1] ? W'(-in_data.num_in) : W'(in_data.num_in);
  assign dmag = in_data.den_in[W-1] ? W'(-in_data.den_in) : W'(in_data.den_in);

  assign tn  = {remn[W-2:0], qn[W-1]};
  assign td  = {remd[W-2:0], qd[W-1]};
  assign gen = tn >= g;
  assign ged = td >= g;

  assign sub_ab = a - b;
  assign sub_ba = b - a;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg  <= in_data.num_in[W-1] ^ in_data.den_in[W-1];
      zero <= (nmag == '0) || (dmag == '0);
      a    <= nmag;
      b    <= dmag;
      qn   <= nmag;
      qd   <= dmag;
      k    <= '0;
    end else if (cmd.halve) begin
      a <= a >> 1;
      b <= b >> 1;
      k <= k + KW'(1);
    end else if (cmd.step) begin
      if (!a[0]) begin
        a <= a >> 1;
      end else if (!b[0]) begin
        b <= b >> 1;
      end else if (a >= b) begin
        a <= sub_ab >> 1;
      end else begin
        b <= sub_ba >> 1;
      end
    end else if (cmd.div_init) begin
      g    <= b << k;
      remn <= '0;
      remd <= '0;
    end else if (cmd.div_step) begin
      remn <= gen ? tn - g : tn;
      remd <= ged ? td - g : td;
      qn   <= {qn[W-2:0], gen};
      qd   <= {qd[W-2:0], ged};
    end
  end

  assign stat.zero      = zero;
  assign stat.both_even = !a[0] && !b[0];
  assign stat.a_zero    = a == '0;

  assign rneg = -qn;

  always_comb begin
    if (zero) begin
      res.num_out = '0;
      res.den_out = (W-1)'(1);
    end else begin
      if (neg) begin
        res.num_out = rneg;
      end else if (qn[W-1]) begin
        res.num_out = {1'b0, {(W-1){1'b1}}};
      end else begin
        res.num_out = qn;
      end
      res.den_out = qd[W-1] ? {(W-1){1'b1}} : qd[W-2:0];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/frg_ctrl.sv @@
// frg_ctrl: sequencer of the fraction reducer; drives frg_dp commands.
// Uses frg_pkg.
`default_nettype none

module frg_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic          out_free,
  output logic               out_load,
  input  wire frg_pkg::stat_t stat,
  output frg_pkg::cmd_t      cmd
);

  localparam int KW = frg_pkg::KW;

  typedef enum logic [2:0] {
    IDLE,
    EVEN,
    GCD,
    DIV,
    FIN
  } state_t;

  state_t        state;
  logic [KW-1:0] cnt;

  assign in_stall = state != IDLE;

  always_comb begin
    cmd      = '0;
    out_load = 1'b0;
    unique case (state)
      IDLE: cmd.load = in_valid;
      EVEN: cmd.halve = !stat.zero && stat.both_even;
      GCD: begin
        cmd.step     = !stat.a_zero;
        cmd.div_init = stat.a_zero;
      end
      DIV: cmd.div_step = 1'b1;
      FIN: out_load = out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        IDLE: if (in_valid) state <= EVEN;
        EVEN: begin
          if (stat.zero) begin
            state <= FIN;
          end else if (!stat.both_even) begin
            state <= GCD;
          end
        end
        GCD: begin
          if (stat.a_zero) begin
            cnt   <= KW'(frg_pkg::W - 1);
            state <= DIV;
          end
        end
        DIV: begin
          if (cnt == '0) begin
            state <= FIN;
          end else begin
            cnt <= cnt - KW'(1);
          end
        end
        FIN: if (out_free) state <= IDLE;
        default: state <= IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/fraction_reduce_gcd.sv @@
// fraction_reduce_gcd: top level of the fraction reducer with output register.
// Depends on frg_pkg, frg_ctrl and frg_dp.
`default_nettype none

// Reduces a signed fraction num/den to lowest terms: num_out carries the sign,
// den_out is positive, and a zero on either input gives 0/1. One item is
// worked at a time. After acceptance the controller halves common factors of
// two, runs a binary gcd loop (at most about 2*W steps), then divides both
// magnitudes by the gcd with two restoring dividers side by side. The time an
// item takes depends on its operands: small operands take fewer gcd steps, and
// a zero operand skips the gcd and the division. The result sits in an
// output register, so a new item is taken while the previous result waits.

module fraction_reduce_gcd (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire frg_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output frg_pkg::out_t      out_data
);

  frg_pkg::cmd_t  cmd;
  frg_pkg::stat_t stat;
  frg_pkg::out_t  res;
  logic           out_free;
  logic           out_load;

  assign out_free = !out_valid || !out_stall;

  frg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_free (out_free),
    .out_load (out_load),
    .stat     (stat),
    .cmd      (cmd)
  );

  frg_dp u_dp (
    .clk     (clk),
    .in_data (in_data),
    .cmd     (cmd),
    .stat    (stat),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= res;
    end
  end

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> out_free)
    else $error("result loaded over a waiting item");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accept");

  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_load |-> res.den_out != '0)
    else $error("zero denominator");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !out_load |=> !out_valid)
    else $error("item delivered twice");
`endif

endmodule

`default_nettype wire
